@@ src/tms_pkg.sv @@
// Shared types and constants for the turtle-mode sequencer.
// Used by turtle_mode_sequencer; depends on nothing else.
package tms_pkg;

    localparam int TIME_BITS   = 32;
    localparam int SAMPLE_BITS = 16;
    localparam int CFG_BITS    = 32;
    localparam int THR_BITS    = 7;

    localparam logic [THR_BITS-1:0] THROTTLE_MAX   = THR_BITS'(100);
    localparam logic [CFG_BITS-1:0] TIMEOUT_RESET  = CFG_BITS'(1000000);
    localparam logic [THR_BITS-1:0] THROTTLE_RESET = THR_BITS'(50);

    typedef enum logic [0:0] {
        CFG_TIMEOUT  = 1'b0,
        CFG_THROTTLE = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        STG_NONE   = 2'd0,
        STG_START  = 2'd1,
        STG_ROTATE = 2'd2,
        STG_EXIT   = 2'd3
    } t_stage;

    typedef struct packed {
        logic                          action;
        logic                          grounded;
        logic                          armed;
        logic                          arm_switch;
        logic signed [SAMPLE_BITS-1:0] gravity_z;
        logic signed [SAMPLE_BITS-1:0] stick_roll;
        logic signed [SAMPLE_BITS-1:0] stick_pitch;
        logic [TIME_BITS-1:0]          now_us;
    } t_in_req;

    typedef struct packed {
        logic                          turtle_active;
        logic                          ctrl_override;
        logic                          motor_override;
        logic                          motor_reverse;
        logic                          arm_safety_set;
        logic signed [SAMPLE_BITS-1:0] override_roll;
        logic signed [SAMPLE_BITS-1:0] override_pitch;
        logic signed [SAMPLE_BITS-1:0] override_yaw;
        logic [THR_BITS-1:0]           override_throttle;
    } t_out_res;

endpackage

@@ src/turtle_mode_sequencer.sv @@
// Turtle-mode sequencer: input register, one pass of decision logic, result register.
// Depends on tms_pkg for the request/result structs, stage enum and constants.
//
//  channel   | direction | handshake                 | payload
//  ----------+-----------+---------------------------+------------------------
//  request   | in        | i_in_valid / o_in_stall   | i_in_req  (t_in_req)
//  result    | out       | o_out_valid / i_out_stall | o_out_res (t_out_res)
//  config    | in        | i_cfg_we (no wait)        | i_cfg_idx, i_cfg_data
//
// An accepted request sits in the input register while the sequencer logic
// works on it; the result register loads from it once the result side is free.
// A new request is accepted every cycle unless the result side stalls; throughput
// is set by the single state update per cycle, which happens as the result register loads.
// Reset (i_rst_n low, synchronous) clears the sequencer state and both valid
// flags and restores the config registers to their defaults.
// A stall on the result side holds the result register; the input register
// then holds too and o_in_stall rises only once it is occupied.
module turtle_mode_sequencer (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  tms_pkg::t_in_req          i_in_req,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output tms_pkg::t_out_res         o_out_res,
    input  logic                      i_cfg_we,
    input  tms_pkg::t_cfg_idx         i_cfg_idx,
    input  logic [tms_pkg::CFG_BITS-1:0] i_cfg_data
);
    import tms_pkg::*;

    // Q2.14 scale points, derived from the sample width
    localparam logic signed [SAMPLE_BITS-1:0] FULL_SCALE = SAMPLE_BITS'(1) << (SAMPLE_BITS - 2);
    localparam logic signed [SAMPLE_BITS-1:0] NEG_FULL   = -FULL_SCALE;
    localparam logic signed [SAMPLE_BITS-1:0] HALF_SCALE = SAMPLE_BITS'(1) << (SAMPLE_BITS - 3);
    localparam logic [SAMPLE_BITS:0]          HALF_MAG   = (SAMPLE_BITS + 1)'(1) << (SAMPLE_BITS - 3);

    // configuration registers
    logic [CFG_BITS-1:0] r_timeout;
    logic [THR_BITS-1:0] r_throttle;

    // pipeline registers
    logic     r_in_vld;
    t_in_req  r_in;
    logic     r_out_vld;
    t_out_res r_out;
    t_out_res n_out;

    // sequencer state
    logic                          r_queued,   n_queued;
    t_stage                        r_stage,    n_stage;
    logic                          r_last_sw,  n_last_sw;
    logic                          r_axis,     n_axis;
    logic                          r_spin_pos, n_spin_pos;
    logic [TIME_BITS-1:0]          r_start,    n_start;
    logic                          r_reverse,  n_reverse;
    logic                          r_ovr,      n_ovr;
    logic signed [SAMPLE_BITS-1:0] r_ovr_roll, n_ovr_roll;
    logic signed [SAMPLE_BITS-1:0] r_ovr_pitch, n_ovr_pitch;
    logic [THR_BITS-1:0]           r_ovr_thr,  n_ovr_thr;

    // decision terms
    t_stage               s_stage;
    logic                 s_safety;
    logic                 s_trigger;
    logic                 s_gz_neg;
    logic                 s_gz_high;
    logic [SAMPLE_BITS:0] s_roll_ext;
    logic [SAMPLE_BITS:0] s_pitch_ext;
    logic [SAMPLE_BITS:0] s_mag_roll;
    logic [SAMPLE_BITS:0] s_mag_pitch;
    logic [TIME_BITS-1:0] s_elapsed;
    logic [THR_BITS-1:0]  s_thr_sat;

    // handshake
    logic out_free;
    logic in_acc;
    logic fire;

    assign out_free    = !r_out_vld || !i_out_stall;
    assign o_in_stall  = r_in_vld && !out_free;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign fire        = r_in_vld && out_free;
    assign o_out_valid = r_out_vld;
    assign o_out_res   = r_out;

    // stick magnitudes, one bit wider so the most negative sample stays exact
    assign s_roll_ext  = {r_in.stick_roll[SAMPLE_BITS-1], r_in.stick_roll};
    assign s_pitch_ext = {r_in.stick_pitch[SAMPLE_BITS-1], r_in.stick_pitch};
    assign s_mag_roll  = r_in.stick_roll[SAMPLE_BITS-1] ? -s_roll_ext : s_roll_ext;
    assign s_mag_pitch = r_in.stick_pitch[SAMPLE_BITS-1] ? -s_pitch_ext : s_pitch_ext;

    assign s_trigger = r_in.arm_switch && !r_last_sw;
    assign s_gz_neg  = r_in.gravity_z[SAMPLE_BITS-1];
    assign s_gz_high = r_in.gravity_z > HALF_SCALE;
    // elapsed time wraps with the free-running counter
    assign s_elapsed = r_in.now_us - r_start;
    assign s_thr_sat = (r_throttle > THROTTLE_MAX) ? THROTTLE_MAX : r_throttle;

    // sequencer next state
    always_comb begin
        n_queued    = r_queued;
        n_stage     = r_stage;
        n_last_sw   = r_last_sw;
        n_axis      = r_axis;
        n_spin_pos  = r_spin_pos;
        n_start     = r_start;
        n_reverse   = r_reverse;
        n_ovr       = r_ovr;
        n_ovr_roll  = r_ovr_roll;
        n_ovr_pitch = r_ovr_pitch;
        n_ovr_thr   = r_ovr_thr;
        s_safety    = 1'b0;
        s_stage     = r_stage;

        if (r_in.action) begin
            // queue request: only when grounded and nothing queued yet
            if (!r_queued && r_in.grounded) begin
                n_queued = 1'b1;
                n_stage  = STG_NONE;
            end
        end else if (!r_queued) begin
            // nothing queued: drop any running sequence, demanding safety if one was running
            if (r_stage != STG_NONE) begin
                n_reverse = 1'b0;
                s_safety  = 1'b1;
            end
            n_stage = STG_NONE;
            n_ovr   = 1'b0;
        end else begin
            n_last_sw = r_in.arm_switch;
            // arming edge while inverted starts; upright again forces exit
            if (s_gz_neg && s_trigger) begin
                s_stage = STG_START;
            end
            if (s_gz_high && s_stage != STG_NONE) begin
                s_stage = STG_EXIT;
            end
            n_stage = s_stage;

            unique case (s_stage)
                STG_START: begin
                    n_ovr       = 1'b1;
                    n_ovr_roll  = '0;
                    n_ovr_pitch = '0;
                    n_ovr_thr   = '0;
                    n_reverse   = 1'b1;
                    n_axis      = 1'b0;
                    n_spin_pos  = 1'b0;
                    if (s_mag_roll > HALF_MAG || s_mag_pitch > HALF_MAG) begin
                        // dominant stick wins; ties go to roll; zero spins negative
                        if (s_mag_roll < s_mag_pitch) begin
                            n_axis     = 1'b1;
                            n_spin_pos = !r_in.stick_pitch[SAMPLE_BITS-1] &&
                                         (|r_in.stick_pitch);
                        end else begin
                            n_spin_pos = !r_in.stick_roll[SAMPLE_BITS-1] &&
                                         (|r_in.stick_roll);
                        end
                        n_stage = STG_ROTATE;
                        n_start = r_in.now_us;
                    end
                end
                STG_ROTATE: begin
                    n_ovr_thr = s_thr_sat;
                    if (r_axis) begin
                        n_ovr_pitch = r_spin_pos ? FULL_SCALE : NEG_FULL;
                    end else begin
                        n_ovr_roll = r_spin_pos ? FULL_SCALE : NEG_FULL;
                    end
                    if (s_elapsed > TIME_BITS'(r_timeout)) begin
                        n_stage = STG_START;
                    end
                end
                STG_EXIT: begin
                    n_queued  = 1'b0;
                    n_stage   = STG_NONE;
                    n_ovr     = 1'b0;
                    n_reverse = 1'b0;
                    s_safety  = 1'b1;
                end
                STG_NONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    // result assembly; override fields read zero while overrides are off
    always_comb begin
        n_out.turtle_active     = (r_stage != STG_NONE) && r_in.armed;
        n_out.ctrl_override     = n_ovr;
        n_out.motor_override    = n_ovr;
        n_out.motor_reverse     = n_reverse;
        n_out.arm_safety_set    = s_safety;
        n_out.override_roll     = n_ovr ? n_ovr_roll : '0;
        n_out.override_pitch    = n_ovr ? n_ovr_pitch : '0;
        n_out.override_yaw      = '0;
        n_out.override_throttle = n_ovr ? n_ovr_thr : '0;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout  <= TIMEOUT_RESET;
            r_throttle <= THROTTLE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TIMEOUT:  r_timeout  <= i_cfg_data;
                CFG_THROTTLE: r_throttle <= i_cfg_data[THR_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // input register: load on accept, hold while the result side is full
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_acc) begin
            r_in_vld <= 1'b1;
        end else if (fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_req;
        end
    end

    // result register: load when the request advances, clear once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= n_out;
        end
    end

    // sequencer state advances together with the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queued    <= 1'b0;
            r_stage     <= STG_NONE;
            r_last_sw   <= 1'b0;
            r_axis      <= 1'b0;
            r_spin_pos  <= 1'b0;
            r_start     <= '0;
            r_reverse   <= 1'b0;
            r_ovr       <= 1'b0;
            r_ovr_roll  <= '0;
            r_ovr_pitch <= '0;
            r_ovr_thr   <= '0;
        end else if (fire) begin
            r_queued    <= n_queued;
            r_stage     <= n_stage;
            r_last_sw   <= n_last_sw;
            r_axis      <= n_axis;
            r_spin_pos  <= n_spin_pos;
            r_start     <= n_start;
            r_reverse   <= n_reverse;
            r_ovr       <= n_ovr;
            r_ovr_roll  <= n_ovr_roll;
            r_ovr_pitch <= n_ovr_pitch;
            r_ovr_thr   <= n_ovr_thr;
        end
    end

    // the exit stage is always resolved within the same request
    a_no_exit_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stage != STG_EXIT)
        else $error("exit stage held in state");

    // a running sequence implies something is queued
    a_idle_unqueued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_queued |-> r_stage == STG_NONE)
        else $error("stage active with nothing queued");

    // rotation always runs with overrides on and motors reversed
    a_rotate_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stage == STG_ROTATE |-> (r_ovr && r_reverse))
        else $error("rotating without override or reverse");

    // a safety demand comes with overrides released
    a_safety_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.arm_safety_set) |->
            (!r_out.ctrl_override && !r_out.motor_reverse))
        else $error("safety demand while still overriding");

endmodule
